// File: design/banker_device_allocator_assert.svh
// assertion macros for the banker device allocator
`ifndef BANKER_DEVICE_ALLOCATOR_ASSERT_SVH
`define BANKER_DEVICE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BDA_CHECK(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("banker allocator check failed");
`define BDA_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("banker allocator sequence check failed");
`else
`define BDA_CHECK(name, prop)
`define BDA_IMPLY(name, cond, prop)
`endif
`endif

// File: design/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// types, sizes and codes shared by the banker device allocator
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int NUM_PROCS   = 16;
    localparam int PID_W       = 4;
    localparam int NUM_DEVICES = 3;
    localparam int DEV_W       = 2;
    localparam int WAIT_DEPTH  = 16;
    localparam int QIDX_W      = 4;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = DEV_W + QIDX_W;
    localparam int MEM_DEPTH   = NUM_DEVICES * WAIT_DEPTH;

    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;

    localparam logic [2:0] ST_INVALID  = 3'd0;
    localparam logic [2:0] ST_EXCEEDS  = 3'd1;
    localparam logic [2:0] ST_UNSAFE   = 3'd2;
    localparam logic [2:0] ST_GRANTED  = 3'd3;
    localparam logic [2:0] ST_QUEUED   = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;
    localparam logic [2:0] ST_NOEFFECT = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    typedef logic [NUM_DEVICES-1:0] dev_mask_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] pid;
        logic [1:0] device;
        logic [2:0] declared_max;
        logic       process_eligible;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] woken_pid;
        logic       finished_valid;
        logic [3:0] next_pid;
        logic       next_valid;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_SETUP,
        CELL_GRANT,
        CELL_COMPLETE,
        CELL_RELEASE,
        CELL_STEP
    } cell_op_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        dev_mask_t        mask;
        dev_mask_t        work;
        logic             tent;
    } cell_cmd_t;

    typedef struct packed {
        dev_mask_t work_or;
        logic      progress;
        logic      unsafe;
    } chain_t;

    typedef struct packed {
        logic      known;
        dev_mask_t alloc;
        dev_mask_t need;
    } cell_view_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SAFE,
        S_POP,
        S_PURGE,
        S_OUT
    } state_t;

endpackage

// File: design/banker_device_allocator.sv
// ----------------------------------------------------------------------------
// banker_device_allocator
// deadlock-avoiding allocator for single-unit devices with fifo wait queues
// ----------------------------------------------------------------------------
// usage:
//  req channel (req_valid/req_stall/req) carries one word per operation:
//  request, i/o completion or release of a process. rsp channel
//  (rsp_valid/rsp_stall/rsp) returns exactly one word per request word.
//  the block works on one word at a time; req_stall is high while busy.
//  steps from accept to rsp_valid:
//   invalid, exceeds, queued, full, completion on idle device: decode, then out
//   completion of a busy device: decode, then pop of the queue head, then out
//   grant or unsafe: decode, then safety passes until no cell can finish, then out;
//     each pass lets every process cell that can finish do so at once,
//     with the returned devices rippling down the cell chain
//   release: decode, then a purge of the process from each device's wait
//     queue in turn, then out
//  the next word can be taken in the cycle in which rsp_valid rises.
//  the result sits in an output register; a stalled result holds while the
//  next word is taken and worked on, and that word waits for the register.
//  reset clears all process cells, marks every device available and empties
//  the queues; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "banker_device_allocator_assert.svh"

module banker_device_allocator
    import bda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    req_t   item_reg;
    rsp_t   res_reg, res_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg, rsp_valid_next;

    dev_mask_t        avail_reg, avail_next;
    dev_mask_t        work_reg, work_next;
    logic             busy_reg [NUM_DEVICES];
    logic             busy_next [NUM_DEVICES];
    logic [PID_W-1:0] owner_reg [NUM_DEVICES];
    logic [PID_W-1:0] owner_next [NUM_DEVICES];
    logic [CNT_W-1:0] cnt_reg [NUM_DEVICES];
    logic [CNT_W-1:0] cnt_next [NUM_DEVICES];
    logic [QIDX_W-1:0] head_reg [NUM_DEVICES];
    logic [QIDX_W-1:0] head_next [NUM_DEVICES];

    logic             chg_reg, chg_next;
    logic [DEV_W-1:0] pd_reg, pd_next;
    logic [CNT_W-1:0] pi_reg, pi_next;
    logic [CNT_W-1:0] pk_reg, pk_next;
    logic             pend_reg, pend_next;

    logic [PID_W-1:0] mem [MEM_DEPTH];
    logic [PID_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [PID_W-1:0] wr_data;
    logic             wr_en;

    cell_op_t   cell_op;
    cell_cmd_t  cmd;
    chain_t     chain [NUM_PROCS+1];
    cell_view_t views [NUM_PROCS];
    cell_view_t pv;

    logic      accept;
    logic      out_free;
    logic      dev_ok;
    dev_mask_t dev_bit;
    dev_mask_t setup_mask;
    dev_mask_t need_eff;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign dev_ok     = (item_reg.device < DEV_W'(NUM_DEVICES));
    assign dev_bit    = dev_mask_t'(1) << item_reg.device;
    assign setup_mask = (item_reg.declared_max[NUM_DEVICES-1:0] == '0) ? dev_bit
                        : item_reg.declared_max[NUM_DEVICES-1:0];
    assign pv         = views[item_reg.pid];
    assign need_eff   = pv.known ? pv.need : setup_mask;

    assign chain[0] = '0;

    for (genvar p = 0; p < NUM_PROCS; p++)
    begin : g_cell
        bda_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (PID_W'(p)),
            .op        (cell_op),
            .cmd       (cmd),
            .chain_in  (chain[p]),
            .chain_out (chain[p+1]),
            .view      (views[p])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        avail_next = avail_reg;
        work_next  = work_reg;
        busy_next  = busy_reg;
        owner_next = owner_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        chg_next   = chg_reg;
        pd_next    = pd_reg;
        pi_next    = pi_reg;
        pk_next    = pk_reg;
        pend_next  = 1'b0;
        cell_op    = CELL_NOP;
        cmd.pid    = item_reg.pid;
        cmd.mask   = dev_bit;
        cmd.work   = work_reg;
        cmd.tent   = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = item_reg.pid;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                res_next        = '0;
                res_next.status = ST_INVALID;
                state_next      = S_OUT;
                case (item_reg.opcode)
                    OP_REQUEST:
                    begin
                        if (dev_ok && item_reg.process_eligible)
                        begin
                            if (!pv.known)
                            begin
                                cell_op  = CELL_SETUP;
                                cmd.mask = setup_mask;
                            end
                            if ((need_eff & dev_bit) == '0)
                                res_next.status = ST_EXCEEDS;
                            else if ((avail_reg & dev_bit) == '0)
                            begin
                                if (cnt_reg[item_reg.device] >= CNT_W'(WAIT_DEPTH))
                                    res_next.status = ST_FULL;
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = {item_reg.device, head_reg[item_reg.device]
                                        + cnt_reg[item_reg.device][QIDX_W-1:0]};
                                    cnt_next[item_reg.device] = cnt_reg[item_reg.device]
                                        + CNT_W'(1);
                                    res_next.status = ST_QUEUED;
                                end
                            end
                            else
                            begin
                                work_next  = avail_reg & ~dev_bit;
                                state_next = S_SAFE;
                            end
                        end
                    end
                    OP_COMPLETE:
                    begin
                        if (dev_ok)
                        begin
                            if (busy_reg[item_reg.device])
                            begin
                                rd_addr    = {item_reg.device, head_reg[item_reg.device]};
                                state_next = S_POP;
                            end
                            else
                                res_next.status = ST_NOEFFECT;
                        end
                    end
                    OP_RELEASE:
                    begin
                        cell_op  = CELL_RELEASE;
                        chg_next = pv.known;
                        if (pv.known)
                            avail_next = avail_reg | pv.alloc;
                        for (int d = 0; d < NUM_DEVICES; d++)
                        begin
                            if (busy_reg[d] && owner_reg[d] == item_reg.pid)
                            begin
                                busy_next[d]  = 1'b0;
                                owner_next[d] = '0;
                                chg_next      = 1'b1;
                            end
                        end
                        pd_next    = '0;
                        pi_next    = '0;
                        pk_next    = '0;
                        state_next = S_PURGE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SAFE:
            begin
                cmd.tent = 1'b1;
                if (chain[NUM_PROCS].progress)
                begin
                    cell_op   = CELL_STEP;
                    work_next = work_reg | chain[NUM_PROCS].work_or;
                end
                else
                begin
                    state_next = S_OUT;
                    if (chain[NUM_PROCS].unsafe)
                        res_next.status = ST_UNSAFE;
                    else
                    begin
                        cell_op    = CELL_GRANT;
                        avail_next = avail_reg & ~dev_bit;
                        busy_next[item_reg.device]  = 1'b1;
                        owner_next[item_reg.device] = item_reg.pid;
                        res_next.status = ST_GRANTED;
                    end
                end
            end
            S_POP:
            begin
                cell_op  = CELL_COMPLETE;
                cmd.pid  = owner_reg[item_reg.device];
                avail_next = avail_reg | dev_bit;
                busy_next[item_reg.device]  = 1'b0;
                owner_next[item_reg.device] = '0;
                res_next.status         = ST_DONE;
                res_next.woken_pid      = owner_reg[item_reg.device];
                res_next.finished_valid = 1'b1;
                if (cnt_reg[item_reg.device] != '0)
                begin
                    res_next.next_pid   = rdata_reg;
                    res_next.next_valid = 1'b1;
                    head_next[item_reg.device] = head_reg[item_reg.device] + QIDX_W'(1);
                    cnt_next[item_reg.device]  = cnt_reg[item_reg.device] - CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_PURGE:
            begin
                // read entry pi while the entry read last cycle is kept or dropped
                rd_addr = {pd_reg, head_reg[pd_reg] + pi_reg[QIDX_W-1:0]};
                if (pi_reg < cnt_reg[pd_reg])
                begin
                    pi_next   = pi_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (rdata_reg == item_reg.pid)
                        chg_next = 1'b1;
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = {pd_reg, head_reg[pd_reg] + pk_reg[QIDX_W-1:0]};
                        wr_data = rdata_reg;
                        pk_next = pk_reg + CNT_W'(1);
                    end
                end
                else if (pi_reg >= cnt_reg[pd_reg])
                begin
                    cnt_next[pd_reg] = pk_reg;
                    pi_next = '0;
                    pk_next = '0;
                    if (pd_reg == DEV_W'(NUM_DEVICES - 1))
                    begin
                        res_next.status = chg_reg ? ST_DONE : ST_NOEFFECT;
                        state_next      = S_OUT;
                    end
                    else
                        pd_next = pd_reg + DEV_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            avail_reg     <= '1;
            work_reg      <= '0;
            chg_reg       <= 1'b0;
            pd_reg        <= '0;
            pi_reg        <= '0;
            pk_reg        <= '0;
            pend_reg      <= 1'b0;
            for (int d = 0; d < NUM_DEVICES; d++)
            begin
                busy_reg[d]  <= 1'b0;
                owner_reg[d] <= '0;
                cnt_reg[d]   <= '0;
                head_reg[d]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            avail_reg     <= avail_next;
            work_reg      <= work_next;
            chg_reg       <= chg_next;
            pd_reg        <= pd_next;
            pi_reg        <= pi_next;
            pk_reg        <= pk_next;
            pend_reg      <= pend_next;
            busy_reg      <= busy_next;
            owner_reg     <= owner_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        res_reg <= res_next;
        if (state_reg == S_OUT && out_free)
            rsp_reg <= res_reg;
    end

    // wait queue memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    `BDA_IMPLY(a_accept_decode, accept, state_reg == S_DECODE)
    `BDA_CHECK(a_rsp_from_out, $rose(rsp_valid) |-> $past(state_reg) == S_OUT)
    `BDA_CHECK(a_pend_in_purge, pend_reg |-> state_reg == S_PURGE)

    for (genvar d = 0; d < NUM_DEVICES; d++)
    begin : g_chk
        `BDA_CHECK(a_cnt_bound, cnt_reg[d] <= CNT_W'(WAIT_DEPTH))
    end

endmodule

// File: design/bda_cell.sv
// ----------------------------------------------------------------------------
// bda_cell
// one process slot: known flag, holdings and remaining need, plus the
// finished flag of the running safety check, chained to its neighbors
// ----------------------------------------------------------------------------
module bda_cell
    import bda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PID_W-1:0] cell_id,
    input  cell_op_t         op,
    input  cell_cmd_t        cmd,
    input  chain_t           chain_in,
    output chain_t           chain_out,
    output cell_view_t       view
);

    logic      known_reg, known_next;
    dev_mask_t alloc_reg, alloc_next;
    dev_mask_t need_reg, need_next;
    logic      done_reg, done_next;
    logic      sel;
    dev_mask_t alloc_eff;
    dev_mask_t need_eff;
    logic      fire;

    assign sel = (cmd.pid == cell_id);

    // the request under test sees its tentative grant
    assign alloc_eff = (sel && cmd.tent) ? (alloc_reg | cmd.mask) : alloc_reg;
    assign need_eff  = (sel && cmd.tent) ? (need_reg & ~cmd.mask) : need_reg;
    assign fire      = known_reg && !done_reg && ((need_eff & ~cmd.work) == '0);

    assign chain_out.work_or  = chain_in.work_or | (fire ? alloc_eff : '0);
    assign chain_out.progress = chain_in.progress | fire;
    assign chain_out.unsafe   = chain_in.unsafe | (known_reg && !done_reg);

    assign view.known = known_reg;
    assign view.alloc = alloc_reg;
    assign view.need  = need_reg;

    always_comb
    begin
        known_next = known_reg;
        alloc_next = alloc_reg;
        need_next  = need_reg;
        done_next  = (op == CELL_STEP) ? (done_reg | fire) : 1'b0;
        if (sel)
        begin
            case (op)
                CELL_SETUP:
                begin
                    known_next = 1'b1;
                    alloc_next = '0;
                    need_next  = cmd.mask;
                end
                CELL_GRANT:
                begin
                    alloc_next = alloc_reg | cmd.mask;
                    need_next  = need_reg & ~cmd.mask;
                end
                CELL_COMPLETE:
                begin
                    alloc_next = alloc_reg & ~cmd.mask;
                    need_next  = need_reg | cmd.mask;
                end
                CELL_RELEASE:
                begin
                    known_next = 1'b0;
                    alloc_next = '0;
                    need_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= 1'b0;
            alloc_reg <= '0;
            need_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            known_reg <= known_next;
            alloc_reg <= alloc_next;
            need_reg  <= need_next;
            done_reg  <= done_next;
        end
    end

endmodule
